// ===== rtl/core/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared constants, operation codes and types for the positional array list.
// ----------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

   // Storage geometry
   localparam int DEPTH       = 64;
   localparam int ENTRY_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int FILL_W      = $clog2(DEPTH + 1);

   // Field widths of the channels
   localparam int OP_W  = 2;
   localparam int POS_W = 8;
   localparam int CAP_W = 7;

   // Width that holds position, fill, capacity and DEPTH for comparisons
   localparam int CMP_W = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;

   // Configuration port
   localparam int PADDR_W = 2;
   localparam int PDATA_W = 32;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_GET    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // Per-cell update select; at most one bit is set in a cycle
   typedef struct packed {
      logic load_value;   // take the inserted word
      logic take_left;    // shift up: take the lower neighbor
      logic take_right;   // shift down: take the upper neighbor
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/pal_if.sv =====
// ----------------------------------------------------------------------------
// pal_if
// Valid/ready channels of the positional array list: request and response.
// ----------------------------------------------------------------------------
`default_nettype none

interface pal_req_if import pal_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [OP_W-1:0]        op;
   logic [POS_W-1:0]       position;
   logic [ENTRY_WIDTH-1:0] value;

   modport source (output valid, output op, output position, output value, input ready);
   modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [ENTRY_WIDTH-1:0] entry;
   logic [FILL_W-1:0]      count;

   modport source (output valid, output ok, output entry, output count, input ready);
   modport sink   (input valid, input ok, input entry, input count, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of words with insert, get, delete and clear at a position.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer (op, position, value); rsp returns
//   exactly one result per operation (ok, entry, count) in order.
//   The list is a row of DEPTH cells; each cell takes the new word or a
//   neighbor's word, so an insert or delete shifts the row from the position
//   upward at the edge that accepts the request, at which the result is also
//   registered. Throughput is one operation per cycle while rsp.ready stays
//   high, set by the single response register; the next request is taken in
//   the cycle its result leaves or while the response register is empty.
//   A stalled response (rsp.ready low) holds the result and drops req.ready.
//   Reset empties the list and sets capacity to 64; no clearing pass runs,
//   since only slots below the fill count are ever read.
//   Capacity is written through the APB-style port at byte address 0 and
//   takes effect on the next operation; it saturates at DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_array_list import pal_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   pal_req_if.sink                 req,
   pal_rsp_if.source               rsp,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   logic [CAP_W-1:0]       capacity;
   logic                   accept;
   logic [CMP_W-1:0]       pos_x;
   logic [CMP_W-1:0]       fill_x;
   logic [CMP_W-1:0]       cap_x;
   logic [CMP_W-1:0]       ins_pos;
   logic                   ins_ok;
   logic                   rd_ok;
   logic                   do_ins;
   logic                   do_del;
   logic                   ok_in;
   logic [ENTRY_WIDTH-1:0] entry_in;
   logic [ENTRY_WIDTH-1:0] cell_data [DEPTH];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   ok_ff;
   logic [ENTRY_WIDTH-1:0] entry_ff;
   logic [FILL_W-1:0]      count_ff;
   logic [FILL_W-1:0]      fill_ff, fill_in;

   pal_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign pos_x  = CMP_W'(req.position);
   assign fill_x = CMP_W'(fill_ff);
   assign cap_x  = CMP_W'(capacity);

   // fill never exceeds DEPTH, so pos < fill also keeps the index in range
   assign ins_ok  = (fill_x < cap_x) && (fill_x < CMP_W'(DEPTH));
   assign ins_pos = (pos_x > fill_x) ? fill_x : pos_x;
   assign rd_ok   = pos_x < fill_x;
   assign do_ins  = accept && (req.op == OP_INSERT) && ins_ok;
   assign do_del  = accept && (req.op == OP_DELETE) && rd_ok;

   // Row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type          ctrl;
      logic [ENTRY_WIDTH-1:0] left_data;
      logic [ENTRY_WIDTH-1:0] right_data;

      assign ctrl.load_value = do_ins && (CMP_W'(i) == ins_pos);
      assign ctrl.take_left  = do_ins && (CMP_W'(i) > ins_pos);
      assign ctrl.take_right = do_del && (CMP_W'(i) >= pos_x);

      if (i == 0) begin : g_first
         assign left_data = req.value;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner_r
         assign right_data = cell_data[i+1];
      end

      pal_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .load_data  (req.value),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      ok_in    = 1'b0;
      entry_in = '0;
      fill_in  = fill_ff;
      case (req.op)
         OP_INSERT: begin
            ok_in = ins_ok;
            if (ins_ok) begin
               fill_in = fill_ff + FILL_W'(1);
            end
         end
         OP_GET, OP_DELETE: begin
            ok_in = rd_ok;
            if (rd_ok) begin
               entry_in = cell_data[pos_x[IDX_W-1:0]];
               if (req.op == OP_DELETE) begin
                  fill_in = fill_ff - FILL_W'(1);
               end
            end
         end
         OP_CLEAR: begin
            ok_in   = 1'b1;
            fill_in = '0;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fill_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff    <= ok_in;
         entry_ff <= entry_in;
         count_ff <= fill_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.ok    = ok_ff;
   assign rsp.entry = entry_ff;
   assign rsp.count = count_ff;

   // fill stays within the row of cells
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(fill_ff) <= CMP_W'(DEPTH))
      else $error("fill exceeds depth");

   // a successful insert grows the list by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      do_ins |=> (count_ff == $past(fill_ff) + FILL_W'(1)) && ok_ff)
      else $error("insert count mismatch");

   // a failed operation leaves the length unchanged and reports no entry
   a_fail_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !ok_in) |=> (fill_ff == $past(fill_ff)) && (entry_ff == '0))
      else $error("failed operation changed state");

   // an accepted request always produces a pending response
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request lost its response");

endmodule

`default_nettype wire

// ===== rtl/core/pal_cell.sv =====
// ----------------------------------------------------------------------------
// pal_cell
// One list slot: holds a word, or takes the new word or a neighbor's word.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_cell import pal_pkg::*; (
   input  wire logic                   clock,
   input  wire cell_ctrl_type          ctrl,
   input  wire logic [ENTRY_WIDTH-1:0] load_data,
   input  wire logic [ENTRY_WIDTH-1:0] left_data,
   input  wire logic [ENTRY_WIDTH-1:0] right_data,
   output logic      [ENTRY_WIDTH-1:0] data
);

   logic [ENTRY_WIDTH-1:0] data_ff;
   logic [ENTRY_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load_value) begin
         data_in = load_data;
      end else if (ctrl.take_left) begin
         data_in = left_data;
      end else if (ctrl.take_right) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pal_csr.sv =====
// ----------------------------------------------------------------------------
// pal_csr
// APB-style register port holding the capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module pal_csr import pal_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output logic      [CAP_W-1:0]   capacity
);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             wr_en;

   // Only register 0 exists, at byte address 0
   assign wr_en = psel && penable && pwrite && (paddr == '0);

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_en) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata   = PDATA_W'(capacity_ff);
   assign pready   = 1'b1;
   assign capacity = capacity_ff;

endmodule

`default_nettype wire

// ===== tb/pal_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pal_scoreboard_pkg
// Tracks the expected contents of the positional array list. Every accepted
// request updates a shadow copy of the list and queues the response it must
// produce; every response transfer is checked against the oldest entry.
// ----------------------------------------------------------------------------

package pal_scoreboard_pkg;
   import pal_pkg::*;

   typedef struct packed {
      logic                   ok;
      logic [ENTRY_WIDTH-1:0] entry;
      logic [FILL_W-1:0]      count;
   } list_result_type;

   class pal_scoreboard;
      logic [ENTRY_WIDTH-1:0] words [DEPTH];
      int unsigned            fill;
      int unsigned            capacity;
      list_result_type        expected_results[$];
      int                     errors;
      int                     n_op[4];
      int                     n_rejected;
      int                     peak_fill;

      function new();
         fill       = 0;
         capacity   = 64;
         errors     = 0;
         n_rejected = 0;
         peak_fill  = 0;
         foreach (n_op[i]) n_op[i] = 0;
      endfunction

      function void set_capacity(int unsigned cap);
         capacity = cap & 'h7f;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function void report_mismatch(string msg);
         errors++;
         if (errors <= 10) $display("[%0t] %s", $realtime, msg);
      endfunction

      // Apply one accepted request to the shadow list and queue its response.
      function void note_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                 logic [ENTRY_WIDTH-1:0] value);
         list_result_type res;
         int unsigned     room;
         int unsigned     at;
         int              i;

         res  = '0;
         room = (capacity > DEPTH) ? DEPTH : capacity;
         n_op[op]++;
         case (op)
            OP_INSERT: begin
               if (fill + 1 <= room) begin
                  at = (pos > fill) ? fill : pos;
                  for (i = fill; i > at; i--) words[i] = words[i-1];
                  words[at] = value;
                  fill++;
                  res.ok = 1'b1;
               end
            end
            OP_GET, OP_DELETE: begin
               // position equal to the length is out of range
               if (pos < fill) begin
                  res.entry = words[pos];
                  res.ok    = 1'b1;
                  if (op == OP_DELETE) begin
                     for (i = pos + 1; i < fill; i++) words[i-1] = words[i];
                     fill--;
                  end
               end
            end
            default: begin
               fill   = 0;
               res.ok = 1'b1;
            end
         endcase
         if (!res.ok) n_rejected++;
         if (fill > peak_fill) peak_fill = fill;
         res.count = FILL_W'(fill);
         expected_results.push_back(res);
      endfunction

      function void check_result(logic ok, logic [ENTRY_WIDTH-1:0] entry,
                                 logic [FILL_W-1:0] count);
         list_result_type want;

         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response ok=%0d entry=%h count=%0d",
                                      ok, entry, count));
            return;
         end
         want = expected_results.pop_front();
         if (want.ok !== ok || want.entry !== entry || want.count !== count)
            report_mismatch($sformatf(
               {"response mismatch: expected ok=%0d entry=%h count=%0d, ",
                "got ok=%0d entry=%h count=%0d"},
               want.ok, want.entry, want.count, ok, entry, count));
      endfunction
   endclass

endpackage

// ===== tb/tb_positional_array_list.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_array_list
// Drives insert, get, delete and clear requests into the list under several
// capacity settings (zero, one, small, below the current length, the full
// depth and above it), with random gaps on the request side and random
// back-pressure on the response side. Responses are checked in order against
// a shadow list kept by the scoreboard.
// ----------------------------------------------------------------------------

module tb_positional_array_list;
   import pal_pkg::*;
   import pal_scoreboard_pkg::*;

   localparam int REG_CAPACITY = 0;

   logic               clock;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;
   bit                 idle_on;
   int unsigned        stall_left;

   pal_req_if req_if();
   pal_rsp_if rsp_if();

   pal_scoreboard sb;

   positional_array_list uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #5ms;
      $display("timeout with %0d responses outstanding", sb.pending());
      $display("tb_positional_array_list failed");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 8);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [POS_W-1:0] pick_position(int unsigned fill);
      int unsigned r;
      int unsigned p;
      r = $urandom_range(0, 99);
      if (r < 80) return POS_W'($urandom_range(0, fill));
      if (r < 90) begin
         p = fill + $urandom_range(1, 3);
         return POS_W'((p > 255) ? 255 : p);
      end
      return POS_W'($urandom_range(0, 255));
   endfunction

   // response side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_if.ready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
         rsp_if.ready = 1'b0;
         stall_left   = pick_gap() - 1;
      end else begin
         rsp_if.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.ok, rsp_if.entry, rsp_if.count);
   end

   // valid stays high after the transfer; the next call either moves on to
   // a new item or drops valid for a gap
   task automatic push_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic [ENTRY_WIDTH-1:0] value);
      int unsigned gap;
      gap = (!idle_on || $urandom_range(0, 99) < 55) ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.op       = op;
      req_if.position = pos;
      req_if.value    = value;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(op, pos, value);
   endtask

   task automatic release_request();
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_capacity(int unsigned cap);
      release_request();
      wait_drained();
      repeat (2) @(posedge clock);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = PADDR_W'(4 * REG_CAPACITY);
      pwdata  = PDATA_W'(cap);
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      sb.set_capacity(cap);
   endtask

   task automatic run_directed();
      idle_on = 1'b0;
      write_capacity(64);
      push_request(OP_GET,    8'd0,   32'h0);          // empty list
      push_request(OP_DELETE, 8'd0,   32'h0);
      push_request(OP_INSERT, 8'd255, 32'hffff_ffff);  // past end appends
      push_request(OP_INSERT, 8'd0,   32'h0000_0000);  // front
      push_request(OP_INSERT, 8'd1,   32'ha5a5_a5a5);  // middle
      push_request(OP_INSERT, 8'd3,   32'h5a5a_5a5a);  // at the length
      push_request(OP_GET,    8'd0,   32'h0);
      push_request(OP_GET,    8'd1,   32'h0);
      push_request(OP_GET,    8'd2,   32'h0);
      push_request(OP_GET,    8'd3,   32'h0);
      push_request(OP_GET,    8'd4,   32'h0);          // position == length
      push_request(OP_DELETE, 8'd4,   32'h0);
      push_request(OP_GET,    8'd255, 32'hffff_ffff);
      push_request(OP_DELETE, 8'd1,   32'h0);
      push_request(OP_DELETE, 8'd0,   32'h0);
      push_request(OP_CLEAR,  8'd0,   32'h0);
      push_request(OP_CLEAR,  8'd255, 32'hffff_ffff);  // clear when empty
      write_capacity(0);
      push_request(OP_INSERT, 8'd0,   32'h1111_1111);  // no room at all
      push_request(OP_GET,    8'd0,   32'h0);
      write_capacity(1);
      push_request(OP_INSERT, 8'd7,   32'h1234_5678);
      push_request(OP_INSERT, 8'd0,   32'h8765_4321);  // full
      push_request(OP_GET,    8'd0,   32'h0);
      push_request(OP_DELETE, 8'd0,   32'h0);
   endtask

   task automatic run_phase(int unsigned cap, int n, int unsigned insert_pct, bit quiet);
      int              k;
      int unsigned     r;
      logic [OP_W-1:0] op;

      write_capacity(cap);
      idle_on = !quiet;
      for (k = 0; k < n; k++) begin
         if (k == n / 2) begin
            release_request();
            wait_drained();
         end
         r = $urandom_range(0, 99);
         if (r < 2) op = OP_CLEAR;
         else if (r < 2 + insert_pct) op = OP_INSERT;
         else if ($urandom_range(0, 1) == 1) op = OP_GET;
         else op = OP_DELETE;
         push_request(op, pick_position(sb.fill), $urandom());
      end
   endtask

   initial begin
      sb              = new();
      reset           = 1'b1;
      idle_on         = 1'b0;
      stall_left      = 0;
      req_if.valid    = 1'b0;
      req_if.op       = OP_INSERT;
      req_if.position = '0;
      req_if.value    = '0;
      rsp_if.ready    = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_phase(64, 150, 60, 1'b0);
      run_phase(127, 80, 70, 1'b1);   // saturates at the depth, no idling
      run_phase(5, 100, 45, 1'b0);
      run_phase(0, 30, 50, 1'b0);
      run_phase(64, 40, 85, 1'b0);    // grow the list, then shrink capacity
      run_phase(3, 60, 50, 1'b0);
      run_phase(1, 40, 50, 1'b0);
      run_phase(33, 100, 50, 1'b0);

      release_request();
      wait_drained();
      repeat (5) @(posedge clock);

      $display("ran %0d inserts, %0d gets, %0d deletes, %0d clears; %0d rejected",
               sb.n_op[OP_INSERT], sb.n_op[OP_GET], sb.n_op[OP_DELETE],
               sb.n_op[OP_CLEAR], sb.n_rejected);
      $display("capacities 0, 1, 3, 5, 33, 64, 127; longest list %0d; %0d mismatches",
               sb.peak_fill, sb.errors);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_positional_array_list passed");
      end else begin
         $display("tb_positional_array_list failed");
      end
      $finish;
   end

endmodule
